>>> rtl/ssnfb_pkg.sv
package ssnfb_pkg;

    localparam int DIGITS_DEF = 4;

    localparam logic [7:0] CMD_DATA  = 8'h40;
    localparam logic [7:0] CMD_ADDR  = 8'hC0;
    localparam logic [7:0] CMD_CTRL  = 8'h80;
    localparam logic [7:0] SEG_MINUS = 8'b01000000;
    localparam logic [7:0] SEG_DOT   = 8'h80;
    localparam logic [7:0] SEG_BLANK = 8'h00;

    localparam logic [3:0] BRIGHT_RST = 4'h0f;

    localparam logic [1:0] FUNC_DEC  = 2'd0;
    localparam logic [1:0] FUNC_HEX  = 2'd1;
    localparam logic [1:0] FUNC_RAW  = 2'd2;
    localparam logic [1:0] FUNC_NONE = 2'd3;

    // floor(x / 10) = (x * 0xCCCD) >> 19, exact for any 16-bit x
    localparam logic [15:0] RECIP10       = 16'hCCCD;
    localparam int          RECIP10_SHIFT = 19;

    typedef struct packed {
        logic [1:0] func;
        logic [15:0] magnitude;
        logic        negative;
        logic [7:0]  dots;
        logic        keep_zeros;
        logic [2:0]  digit_count;
        logic [1:0]  start_position;
        logic [7:0]  raw_segment_0;
        logic [7:0]  raw_segment_1;
        logic [7:0]  raw_segment_2;
        logic [7:0]  raw_segment_3;
    } t_req;

    typedef struct packed {
        logic [7:0] bus_byte;
        logic       frame_start;
        logic       frame_end;
        logic       last;
    } t_res;

    // microcode
    localparam int PC_W = 3;
    typedef logic [PC_W-1:0] t_pc;

    localparam t_pc STEP_WAIT  = 3'd0;
    localparam t_pc STEP_CHECK = 3'd1;
    localparam t_pc STEP_DIGIT = 3'd2;
    localparam t_pc STEP_DATA  = 3'd3;
    localparam t_pc STEP_ADDR  = 3'd4;
    localparam t_pc STEP_SEG   = 3'd5;
    localparam t_pc STEP_CTRL  = 3'd6;

    typedef enum logic [1:0] {
        ACT_NONE,
        ACT_DIGIT,
        ACT_EMIT
    } t_act;

    typedef enum logic [1:0] {
        SEL_DATA,
        SEL_ADDR,
        SEL_SEG,
        SEL_CTRL
    } t_sel;

    typedef enum logic [2:0] {
        COND_NEXT,
        COND_ALWAYS,
        COND_IDLE,
        COND_FUNC_NONE,
        COND_MORE_DIG,
        COND_MORE_SEG
    } t_cond;

    typedef struct packed {
        t_act  act;
        t_sel  sel;
        logic  fstart;
        logic  fend;
        logic  flast;
        t_cond cond;
        t_pc   target;
    } t_uword;

    typedef struct packed {
        logic accept;
        logic func_none;
        logic more_dig;
        logic more_seg;
    } t_seq_flags;

    function automatic t_uword ucode(input t_pc pc);
        t_uword w;
        w = '{act: ACT_NONE, sel: SEL_DATA, fstart: 1'b0, fend: 1'b0, flast: 1'b0,
              cond: COND_NEXT, target: STEP_WAIT};
        unique case (pc)
            STEP_WAIT: begin
                w.cond   = COND_IDLE;
                w.target = STEP_WAIT;
            end
            STEP_CHECK: begin
                w.cond   = COND_FUNC_NONE;
                w.target = STEP_WAIT;
            end
            STEP_DIGIT: begin
                w.act    = ACT_DIGIT;
                w.cond   = COND_MORE_DIG;
                w.target = STEP_DIGIT;
            end
            STEP_DATA: begin
                w.act    = ACT_EMIT;
                w.sel    = SEL_DATA;
                w.fstart = 1'b1;
                w.fend   = 1'b1;
            end
            STEP_ADDR: begin
                w.act    = ACT_EMIT;
                w.sel    = SEL_ADDR;
                w.fstart = 1'b1;
            end
            STEP_SEG: begin
                w.act    = ACT_EMIT;
                w.sel    = SEL_SEG;
                w.cond   = COND_MORE_SEG;
                w.target = STEP_SEG;
            end
            STEP_CTRL: begin
                w.act    = ACT_EMIT;
                w.sel    = SEL_CTRL;
                w.fstart = 1'b1;
                w.fend   = 1'b1;
                w.flast  = 1'b1;
                w.cond   = COND_ALWAYS;
                w.target = STEP_WAIT;
            end
            default: begin
                w.cond   = COND_ALWAYS;
                w.target = STEP_WAIT;
            end
        endcase
        return w;
    endfunction

    function automatic logic [7:0] seg_font(input logic [3:0] d);
        logic [7:0] s;
        unique case (d)
            4'h0: s = 8'b00111111;
            4'h1: s = 8'h06;
            4'h2: s = 8'h5B;
            4'h3: s = 8'h4F;
            4'h4: s = 8'h66;
            4'h5: s = 8'h6D;
            4'h6: s = 8'h7D;
            4'h7: s = 8'h07;
            4'h8: s = 8'b01111111;
            4'h9: s = 8'h6F;
            4'hA: s = 8'h77;
            4'hB: s = 8'h7C;
            4'hC: s = 8'h39;
            4'hD: s = 8'h5E;
            4'hE: s = 8'h79;
            4'hF: s = 8'h71;
        endcase
        return s;
    endfunction

endpackage

>>> rtl/seven_segment_number_frame_builder_top.sv
// Seven-segment frame builder. Pulse start while busy is low to hand over one display
// request (decimal, hex or raw segment bytes); the block then raises busy and emits
// 3 + n bytes on o_result, one per o_strobe cycle, where n is digit_count clamped to
// 1..DIGITS: the data command, the address byte, n segment bytes and the display
// control byte carrying the brightness register. The receiver cannot stall: every
// strobed byte must be taken in the cycle it appears. A microcoded sequencer extracts
// one digit per cycle through a shared divide-by-base unit and then emits one byte per
// cycle; busy stays high, and no new request is accepted, until the display control
// byte has been issued. Function code 3 is accepted and produces no bytes. The
// brightness register (reset 0xF) is written through the cfg channel, which is always
// ready; write it only while busy is low and no bytes are pending.
module seven_segment_number_frame_builder_top
    import ssnfb_pkg::*;
#(
    parameter int DIGITS = DIGITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       start,
    output logic       busy,
    input  t_req       i_req,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [3:0] i_cfg_data,
    output logic       o_strobe,
    output t_res       o_result
);

    localparam int IDX_W = (DIGITS > 1) ? $clog2(DIGITS) : 1;

    // sequencer
    t_uword     uw;
    t_seq_flags flags;
    logic       accept;

    // request registers
    t_req             r_req;
    logic [15:0]      r_num;
    logic             r_neg;
    logic             r_zblank;
    logic [IDX_W-1:0] r_idx;
    logic [IDX_W-1:0] r_last_idx;
    logic [3:0]       r_bright;
    logic [7:0]       r_seg [DIGITS];

    // output register
    logic r_strobe;
    logic n_strobe;
    t_res r_result;
    t_res n_result;

    logic [3:0]       cnt4;
    logic [3:0]       cnt_eff;
    logic [IDX_W-1:0] ld_last_idx;

    logic [31:0] prod;
    logic [15:0] q_dec;
    logic [15:0] rem_dec;
    logic [15:0] quot;
    logic [3:0]  digit;
    logic        num_zero;
    logic [7:0]  raw_sel;
    logic [7:0]  seg_next;
    logic        use_minus;
    logic        dot_en;
    logic        dot;

    assign accept = start && !busy;

    assign flags = '{accept:    accept,
                     func_none: (r_req.func == FUNC_NONE),
                     more_dig:  (r_idx != '0),
                     more_seg:  (r_idx != r_last_idx)};

    ssnfb_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_flags (flags),
        .o_uword (uw),
        .o_busy  (busy)
    );

    // Clamp the digit count to 1..DIGITS and keep it as the index of the last place.
    always_comb begin
        cnt4 = {1'b0, i_req.digit_count};
        if (cnt4 == 4'd0) begin
            cnt_eff = 4'd1;
        end else if (cnt4 > 4'(DIGITS)) begin
            cnt_eff = 4'(DIGITS);
        end else begin
            cnt_eff = cnt4;
        end
        ld_last_idx = IDX_W'(cnt_eff - 4'd1);
    end

    // Divide by the base: reciprocal multiply for ten, a shift for sixteen.
    always_comb begin
        prod    = 32'(r_num) * 32'(RECIP10);
        q_dec   = 16'(prod >> RECIP10_SHIFT);
        rem_dec = r_num - 16'(q_dec * 16'd10);
        if (r_req.func == FUNC_HEX) begin
            quot  = {4'b0000, r_num[15:4]};
            digit = r_num[3:0];
        end else begin
            quot  = q_dec;
            digit = rem_dec[3:0];
        end
        num_zero = (r_num == 16'd0);
    end

    always_comb begin
        case (int'(r_idx))
            0:       raw_sel = r_req.raw_segment_0;
            1:       raw_sel = r_req.raw_segment_1;
            2:       raw_sel = r_req.raw_segment_2;
            3:       raw_sel = r_req.raw_segment_3;
            default: raw_sel = SEG_BLANK;
        endcase
    end

    // Segment code for the place under r_idx, walking from the right.
    always_comb begin
        use_minus = 1'b0;
        if (r_zblank) begin
            // zero with blanking: a single 0 in the rightmost place
            seg_next = (r_idx == r_last_idx) ? seg_font(4'h0) : SEG_BLANK;
        end else if (r_req.func == FUNC_RAW) begin
            seg_next = raw_sel;
        end else begin
            if (num_zero && !r_req.keep_zeros) begin
                seg_next = SEG_BLANK;
            end else begin
                seg_next = seg_font(digit);
            end
            if (num_zero && r_neg) begin
                seg_next  = SEG_MINUS;
                use_minus = 1'b1;
            end
        end
    end

    // Dot mask: bit 7 belongs to the leftmost written place.
    always_comb begin
        dot_en = !r_zblank && (r_req.func != FUNC_RAW);
        dot    = 1'b0;
        if (dot_en && (int'(r_idx) < 8)) begin
            dot = r_req.dots[3'(7 - int'(r_idx))];
        end
    end

    always_comb begin
        n_strobe = (uw.act == ACT_EMIT);
        n_result = '{bus_byte: CMD_DATA, frame_start: uw.fstart, frame_end: uw.fend,
                     last: uw.flast};
        unique case (uw.sel)
            SEL_DATA: n_result.bus_byte = CMD_DATA;
            SEL_ADDR: n_result.bus_byte = CMD_ADDR | {6'd0, r_req.start_position};
            SEL_SEG: begin
                n_result.bus_byte  = r_seg[r_idx] | (dot ? SEG_DOT : SEG_BLANK);
                n_result.frame_end = (r_idx == r_last_idx);
            end
            SEL_CTRL: n_result.bus_byte = CMD_CTRL | {4'd0, r_bright};
            default:  n_result.bus_byte = CMD_DATA;
        endcase
    end

    // Control state: strobe and brightness.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
            r_bright <= BRIGHT_RST;
        end else begin
            r_strobe <= n_strobe;
            if (i_cfg_valid && o_cfg_ready) begin
                r_bright <= i_cfg_data;
            end
        end
    end

    // Datapath: latch the request, extract digits, step through the places.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_req      <= i_req;
            r_num      <= i_req.magnitude;
            r_neg      <= i_req.negative && (i_req.func == FUNC_DEC);
            r_zblank   <= (i_req.func != FUNC_RAW) && (i_req.magnitude == 16'd0)
                          && !i_req.keep_zeros;
            r_idx      <= ld_last_idx;
            r_last_idx <= ld_last_idx;
        end else if (uw.act == ACT_DIGIT) begin
            r_seg[r_idx] <= seg_next;
            r_num        <= quot;
            if (use_minus) begin
                r_neg <= 1'b0;
            end
            if (r_idx != '0) begin
                r_idx <= r_idx - IDX_W'(1);
            end
        end else if ((uw.act == ACT_EMIT) && (uw.sel == SEL_SEG)) begin
            if (r_idx != r_last_idx) begin
                r_idx <= r_idx + IDX_W'(1);
            end
        end
    end

    // Payload register: hold the last byte between strobes.
    always_ff @(posedge i_clk) begin
        if (n_strobe) begin
            r_result <= n_result;
        end
    end

    assign o_cfg_ready = 1'b1;
    assign o_strobe    = r_strobe;
    assign o_result    = r_result;

    // A byte only appears while a request is in progress.
    a_strobe_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(busy))
        else $error("byte transfer without a request in progress");

    // The final byte leaves the block free for the next request.
    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_result.last) |-> !busy)
        else $error("block still busy after the final byte");

    // An accepted request makes the block busy.
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("request accepted but block not busy");

    // The address byte is followed at once by a segment byte.
    a_addr_seg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_result.frame_start && !o_result.frame_end)
        |=> (o_strobe && !o_result.frame_start))
        else $error("address byte not followed by segment data");

endmodule

>>> rtl/ssnfb_seq.sv
module ssnfb_seq
    import ssnfb_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_seq_flags i_flags,
    output t_uword     o_uword,
    output logic       o_busy
);

    t_pc    r_pc;
    t_pc    n_pc;
    t_uword uw;
    logic   jump;

    assign uw = ucode(r_pc);

    always_comb begin
        unique case (uw.cond)
            COND_NEXT:      jump = 1'b0;
            COND_ALWAYS:    jump = 1'b1;
            COND_IDLE:      jump = !i_flags.accept;
            COND_FUNC_NONE: jump = i_flags.func_none;
            COND_MORE_DIG:  jump = i_flags.more_dig;
            COND_MORE_SEG:  jump = i_flags.more_seg;
            default:        jump = 1'b1;
        endcase
        n_pc = jump ? uw.target : t_pc'(r_pc + t_pc'(1));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= STEP_WAIT;
        end else begin
            r_pc <= n_pc;
        end
    end

    assign o_uword = uw;
    assign o_busy  = (r_pc != STEP_WAIT);

endmodule
